### rtl/grws_pkg.sv
// ----------------------------------------------------------------------------
// grws_pkg
// Shared types and codes of the grid random walk stepper: beat payloads,
// item kinds, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package grws_pkg;

  localparam int CoordW   = 6;
  localparam int DimW     = 7;
  localparam int ProbW    = 10;
  localparam int StepsW   = 21;
  localparam int MaxStepW = 20;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_WALKING = 2'd0,
    ST_CENTER  = 2'd1,
    ST_LIMIT   = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH   = 3'd0,
    CFG_GRID_HEIGHT  = 3'd1,
    CFG_PROB_UP      = 3'd2,
    CFG_PROB_DOWN    = 3'd3,
    CFG_PROB_LEFT    = 3'd4,
    CFG_OBSTACLES_ON = 3'd5,
    CFG_MAX_STEPS    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              blocked;
    logic [ProbW-1:0]  rand_value;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [StepsW-1:0] step_count;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_item_t;

endpackage

### rtl/grws_chan_if.sv
// ----------------------------------------------------------------------------
// grws_chan_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface grws_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/grws_map_ram.sv
// ----------------------------------------------------------------------------
// grws_map_ram
// One-bit obstacle map: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module grws_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/grid_random_walk_stepper_unit.sv
// ----------------------------------------------------------------------------
// grid_random_walk_stepper_unit
// Lattice random walker heading for the grid center, with an obstacle map
// held in a synchronous RAM.
//
//   channel | dir | modport | payload
//   --------+-----+---------+-------------------------------------------
//   in_i    | in  | sink    | kind, cell_x, cell_y, blocked, rand_value
//   out_o   | out | source  | pos_x, pos_y, step_count, status
//   cfg_i   | in  | sink    | index, wdata (always ready)
//
// Start and step items pass the accept cycle, which forms the candidate cell
// and, for a step with obstacles on, issues its map read, then the resolve
// stage, which resolves the move and writes the walker registers; the next
// item enters once that stage has emptied. Map writes and unused kinds skip
// the resolve stage and yield no beat. After reset a clearing pass writes all
// LIM_W*LIM_H map cells (4096 at default sizes) empty, one cell a cycle, and
// no item is taken meanwhile. A result waits in the output register; a stall
// there holds the resolve stage but the block still accepts one more item.
// ----------------------------------------------------------------------------
module grid_random_walk_stepper_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PROB_SCALE = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  grws_chan_if.sink   in_i,
  grws_chan_if.source out_o,
  grws_chan_if.sink   cfg_i
);

  // Coordinates are 6 bits wide, so the usable grid never exceeds 64 x 64.
  localparam int LIM_W     = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int LIM_H     = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam int MAP_DEPTH = LIM_W * LIM_H;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int RW        = grws_pkg::ProbW;
  localparam int CW        = grws_pkg::CoordW;
  localparam int DW        = grws_pkg::DimW;

  typedef struct packed {
    logic          is_start;
    logic [CW-1:0] tgt_x;
    logic [CW-1:0] tgt_y;
    logic          ok;
    logic          need_map;
  } s1_t;

  // Configuration registers.
  logic [DW-1:0]                   grid_w_q, grid_h_q;
  logic [RW-1:0]                   prob_up_q, prob_down_q, prob_left_q;
  logic                            obst_on_q;
  logic [grws_pkg::MaxStepW-1:0]   max_steps_q;

  // Walker state.
  logic [CW-1:0]                   walk_x_q, walk_y_q, walk_x_d, walk_y_d;
  logic [grws_pkg::StepsW-1:0]     steps_q, steps_d;
  logic                            active_q, active_d;

  // Clearing pass.
  logic                            clr_busy_q;
  logic [AW-1:0]                   clr_cnt_q;

  // Resolve stage and output register.
  logic                            s1_valid_q;
  s1_t                             s1_q, s1_d;
  logic                            s1_fire;
  logic                            out_valid_q;
  grws_pkg::out_item_t             out_q, out_d;

  // Accept-side signals.
  logic                            in_fire;
  logic                            is_map, is_start, is_step;
  logic [DW-1:0]                   eff_w, eff_h;
  logic [RW-1:0]                   r_red;
  logic [RW:0]                     sum_ud;
  logic [RW+1:0]                   sum_udl;
  logic [DW-1:0]                   nx, ny;
  logic                            nx_neg, ny_neg;
  logic                            in_grid;
  logic [DW-1:0]                   wrap_x, wrap_y;

  // Map RAM ports.
  logic                            map_we, map_wdata, map_re, map_rdata;
  logic [AW-1:0]                   map_waddr, map_raddr;

  // Resolve-side signals.
  logic                            moved;
  grws_pkg::status_e               status;
  logic [grws_pkg::StepsW-1:0]     count;
  logic [grws_pkg::StepsW-1:0]     steps_inc;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_i.ready  = !clr_busy_q && !s1_valid_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign is_map   = (in_i.data.kind == grws_pkg::KIND_MAP);
  assign is_start = (in_i.data.kind == grws_pkg::KIND_START);
  assign is_step  = (in_i.data.kind == grws_pkg::KIND_STEP);

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q    <= DW'(64);
      grid_h_q    <= DW'(64);
      prob_up_q   <= RW'(250);
      prob_down_q <= RW'(250);
      prob_left_q <= RW'(250);
      obst_on_q   <= 1'b0;
      max_steps_q <= grws_pkg::MaxStepW'(100000);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        grws_pkg::CFG_GRID_WIDTH:   grid_w_q    <= cfg_i.data.wdata[DW-1:0];
        grws_pkg::CFG_GRID_HEIGHT:  grid_h_q    <= cfg_i.data.wdata[DW-1:0];
        grws_pkg::CFG_PROB_UP:      prob_up_q   <= cfg_i.data.wdata[RW-1:0];
        grws_pkg::CFG_PROB_DOWN:    prob_down_q <= cfg_i.data.wdata[RW-1:0];
        grws_pkg::CFG_PROB_LEFT:    prob_left_q <= cfg_i.data.wdata[RW-1:0];
        grws_pkg::CFG_OBSTACLES_ON: obst_on_q   <= cfg_i.data.wdata[0];
        grws_pkg::CFG_MAX_STEPS:    max_steps_q <= cfg_i.data.wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp the grid size to 1..limit.
  always_comb begin
    if (grid_w_q == '0) begin
      eff_w = DW'(1);
    end else if (grid_w_q > DW'(LIM_W)) begin
      eff_w = DW'(LIM_W);
    end else begin
      eff_w = grid_w_q;
    end
    if (grid_h_q == '0) begin
      eff_h = DW'(1);
    end else if (grid_h_q > DW'(LIM_H)) begin
      eff_h = DW'(LIM_H);
    end else begin
      eff_h = grid_h_q;
    end
  end

  // --------------------------------------------------------------------------
  // Accept cycle: reduce the draw, pick a direction, form the candidate cell
  // --------------------------------------------------------------------------
  // Reduce the draw modulo PROB_SCALE by conditional subtraction of shifted
  // multiples; only multiples that fit in the draw's width take part.
  always_comb begin
    r_red = in_i.data.rand_value;
    for (int k = RW - 1; k >= 0; k--) begin
      if ((32'(PROB_SCALE) << k) < (32'd1 << RW)) begin
        if (32'(r_red) >= (32'(PROB_SCALE) << k)) begin
          r_red = r_red - RW'(32'(PROB_SCALE) << k);
        end
      end
    end
  end

  assign sum_ud  = (RW+1)'(prob_up_q) + (RW+1)'(prob_down_q);
  assign sum_udl = (RW+2)'(sum_ud) + (RW+2)'(prob_left_q);

  // Cumulative thresholds: up, then up+down, then up+down+left, else right.
  always_comb begin
    nx     = {1'b0, walk_x_q};
    ny     = {1'b0, walk_y_q};
    nx_neg = 1'b0;
    ny_neg = 1'b0;
    priority if ((RW+2)'(r_red) < (RW+2)'(prob_up_q)) begin
      ny_neg = (walk_y_q == '0);
      ny     = {1'b0, walk_y_q} - DW'(1);
    end else if ((RW+2)'(r_red) < (RW+2)'(sum_ud)) begin
      ny     = {1'b0, walk_y_q} + DW'(1);
    end else if ((RW+2)'(r_red) < sum_udl) begin
      nx_neg = (walk_x_q == '0);
      nx     = {1'b0, walk_x_q} - DW'(1);
    end else begin
      nx     = {1'b0, walk_x_q} + DW'(1);
    end
  end

  assign in_grid = !nx_neg && (nx < eff_w) && !ny_neg && (ny < eff_h);
  assign wrap_x  = nx_neg ? (eff_w - DW'(1)) : ((nx >= eff_w) ? '0 : nx);
  assign wrap_y  = ny_neg ? (eff_h - DW'(1)) : ((ny >= eff_h) ? '0 : ny);

  always_comb begin
    s1_d = '0;
    if (is_start) begin
      s1_d.is_start = 1'b1;
      s1_d.tgt_x    = in_i.data.cell_x;
      s1_d.tgt_y    = in_i.data.cell_y;
      s1_d.ok       = 1'b1;
    end else if (obst_on_q) begin
      s1_d.tgt_x    = nx[CW-1:0];
      s1_d.tgt_y    = ny[CW-1:0];
      s1_d.ok       = in_grid;
      s1_d.need_map = 1'b1;
    end else begin
      s1_d.tgt_x    = wrap_x[CW-1:0];
      s1_d.tgt_y    = wrap_y[CW-1:0];
      s1_d.ok       = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Obstacle map: clearing pass, map writes, candidate reads
  // --------------------------------------------------------------------------
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_cnt_q;
    map_wdata = 1'b0;
    if (clr_busy_q) begin
      map_we = 1'b1;
    end else if (in_fire && is_map &&
                 (DW'(in_i.data.cell_x) < DW'(LIM_W)) &&
                 (DW'(in_i.data.cell_y) < DW'(LIM_H))) begin
      map_we    = 1'b1;
      map_waddr = AW'(AW'(in_i.data.cell_y) * AW'(LIM_W)) + AW'(in_i.data.cell_x);
      map_wdata = in_i.data.blocked;
    end
  end

  // Read only when the candidate lies inside the grid; the address is valid
  // only then.
  assign map_re    = in_fire && is_step && obst_on_q && in_grid;
  assign map_raddr = AW'(AW'(ny[CW-1:0]) * AW'(LIM_W)) + AW'(nx[CW-1:0]);

  grws_map_ram #(
    .DEPTH (MAP_DEPTH),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(MAP_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Resolve cycle: take the move, count the step (a start clears the count), evaluate the status
  // --------------------------------------------------------------------------
  assign moved     = s1_q.ok && !(s1_q.need_map && map_rdata);
  assign steps_inc = steps_q + grws_pkg::StepsW'(1);

  always_comb begin
    walk_x_d = walk_x_q;
    walk_y_d = walk_y_q;
    steps_d  = steps_q;
    active_d = active_q;
    status   = grws_pkg::ST_IDLE;
    count    = steps_q;
    if (s1_q.is_start || active_q) begin
      if (s1_q.is_start) begin
        steps_d = '0;
      end else begin
        steps_d = steps_inc;
      end
      if (moved) begin
        walk_x_d = s1_q.tgt_x;
        walk_y_d = s1_q.tgt_y;
      end
      count = steps_d;
      if (steps_d > grws_pkg::StepsW'(max_steps_q)) begin
        status   = grws_pkg::ST_LIMIT;
        count    = grws_pkg::StepsW'(max_steps_q) + grws_pkg::StepsW'(1);
        active_d = 1'b0;
      end else if (({1'b0, walk_x_d} == (eff_w >> 1)) &&
                   ({1'b0, walk_y_d} == (eff_h >> 1))) begin
        status   = grws_pkg::ST_CENTER;
        active_d = 1'b0;
      end else begin
        status   = grws_pkg::ST_WALKING;
        active_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_d.pos_x      = walk_x_d;
    out_d.pos_y      = walk_y_d;
    out_d.step_count = count;
    out_d.status     = status;
  end

  // Control state: stage valid, output valid, walker registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      steps_q     <= '0;
      active_q    <= 1'b0;
    end else begin
      if (in_fire && (is_start || is_step)) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        walk_x_q    <= walk_x_d;
        walk_y_q    <= walk_y_d;
        steps_q     <= steps_d;
        active_q    <= active_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  // No item enters during the clearing pass.
  a_clr_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !in_i.ready
  ) else $error("item accepted during map clearing pass");

  // A start or step item occupies the resolve stage in the cycle after it is accepted.
  a_walk_item_enters: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (is_start || is_step)) |=> s1_valid_q
  ) else $error("start or step item lost before resolve");

  // A resolved item shows up as an output beat.
  a_resolve_to_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_fire |=> out_valid_q
  ) else $error("resolved item did not reach output register");

  // The map is never read while it is still being cleared.
  a_no_read_in_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni) map_re |-> !clr_busy_q
  ) else $error("map read during clearing pass");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid random walk stepper. A scoreboard class
// tracks the walker, the obstacle map and the register settings, forecasts
// the result beat of every start and step item and checks each output beat
// in order. Directed items cover the edge cases, then random walks run under
// several random register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          HALF_PERIOD   = 4;
  localparam int          RESET_CYCLES  = 10;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          TAIL_CYCLES   = 8;
  localparam int          IDLE_PCT      = 19;
  localparam int          MAX_SHOWN     = 10;
  localparam int          GRID_LIM      = 64;
  localparam int          MAP_CELLS     = GRID_LIM * GRID_LIM;
  localparam int          PERMILLE      = 1000;
  localparam int          RAND_ITEMS    = 1950;
  localparam int          NUM_PHASES    = 8;
  localparam int          QUIET_PHASE   = 3;
  localparam int          PAUSE_PHASE   = 5;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam logic [19:0] STEPS_ALL_ONE = 20'hFFFFF;

  typedef logic [grws_pkg::CoordW-1:0]   coord_t;
  typedef logic [grws_pkg::ProbW-1:0]    rand_t;
  typedef logic [grws_pkg::CfgDataW-1:0] cfg_data_t;

  // --------------------------------------------------------------------------
  // Walk scoreboard: mirrors the block state and holds the pending results
  // --------------------------------------------------------------------------
  class walk_scoreboard;
    logic [grws_pkg::DimW-1:0]     grid_w, grid_h;
    logic [grws_pkg::ProbW-1:0]    p_up, p_down, p_left;
    logic                          obst_on;
    logic [grws_pkg::MaxStepW-1:0] step_limit;
    bit                            cell_blocked [MAP_CELLS];
    coord_t                        wx, wy;
    logic [grws_pkg::StepsW-1:0]   steps;
    bit                            walking;
    grws_pkg::out_item_t           expected_q [$];
    int                            errors;

    function new();
      grid_w     = 7'd64;
      grid_h     = 7'd64;
      p_up       = 10'd250;
      p_down     = 10'd250;
      p_left     = 10'd250;
      obst_on    = 1'b0;
      step_limit = 20'd100000;
      foreach (cell_blocked[i]) cell_blocked[i] = 1'b0;
      wx      = '0;
      wy      = '0;
      steps   = '0;
      walking = 1'b0;
      errors  = 0;
    endfunction

    function int eff_dim(logic [grws_pkg::DimW-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_LIM) return GRID_LIM;
      return int'(v);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("%s", msg);
    endfunction

    function void apply_reg(logic [grws_pkg::CfgIdxW-1:0] idx,
                            logic [grws_pkg::CfgDataW-1:0] value);
      case (idx)
        grws_pkg::CFG_GRID_WIDTH:   grid_w     = value[grws_pkg::DimW-1:0];
        grws_pkg::CFG_GRID_HEIGHT:  grid_h     = value[grws_pkg::DimW-1:0];
        grws_pkg::CFG_PROB_UP:      p_up       = value[grws_pkg::ProbW-1:0];
        grws_pkg::CFG_PROB_DOWN:    p_down     = value[grws_pkg::ProbW-1:0];
        grws_pkg::CFG_PROB_LEFT:    p_left     = value[grws_pkg::ProbW-1:0];
        grws_pkg::CFG_OBSTACLES_ON: obst_on    = value[0];
        grws_pkg::CFG_MAX_STEPS:    step_limit = value[grws_pkg::MaxStepW-1:0];
        default: ;
      endcase
    endfunction

    // Forecast the result of one accepted input beat, if it has one.
    function void note_input(grws_pkg::in_item_t it);
      int                  w, h, nx, ny, draw;
      grws_pkg::out_item_t e;
      w    = eff_dim(grid_w);
      h    = eff_dim(grid_h);
      draw = int'(it.rand_value) % PERMILLE;
      case (it.kind)
        grws_pkg::KIND_MAP: begin
          cell_blocked[int'(it.cell_y) * GRID_LIM + int'(it.cell_x)] = it.blocked;
          return;
        end
        grws_pkg::KIND_START: begin
          wx      = it.cell_x;
          wy      = it.cell_y;
          steps   = '0;
          walking = 1'b1;
        end
        grws_pkg::KIND_STEP: begin
          if (!walking) begin
            e.pos_x      = wx;
            e.pos_y      = wy;
            e.step_count = steps;
            e.status     = grws_pkg::ST_IDLE;
            expected_q.push_back(e);
            return;
          end
          nx = int'(wx);
          ny = int'(wy);
          if (draw < int'(p_up)) ny--;
          else if (draw < int'(p_up) + int'(p_down)) ny++;
          else if (draw < int'(p_up) + int'(p_down) + int'(p_left)) nx--;
          else nx++;
          if (obst_on) begin
            if (nx >= 0 && nx < w && ny >= 0 && ny < h &&
                !cell_blocked[ny * GRID_LIM + nx]) begin
              wx = coord_t'(nx);
              wy = coord_t'(ny);
            end
          end else begin
            wx = coord_t'((nx < 0) ? w - 1 : ((nx >= w) ? 0 : nx));
            wy = coord_t'((ny < 0) ? h - 1 : ((ny >= h) ? 0 : ny));
          end
          steps = steps + 1'b1;
        end
        default: return;
      endcase
      e.pos_x      = wx;
      e.pos_y      = wy;
      e.step_count = steps;
      if (steps > {1'b0, step_limit}) begin
        e.step_count = {1'b0, step_limit} + 1'b1;
        e.status     = grws_pkg::ST_LIMIT;
        walking      = 1'b0;
      end else if (int'(wx) == w / 2 && int'(wy) == h / 2) begin
        e.status = grws_pkg::ST_CENTER;
        walking  = 1'b0;
      end else begin
        e.status = grws_pkg::ST_WALKING;
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(grws_pkg::out_item_t got);
      grws_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result beat: x=%0d y=%0d n=%0d st=%0d",
                             got.pos_x, got.pos_y, got.step_count, got.status));
        return;
      end
      e = expected_q.pop_front();
      if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y ||
          got.step_count !== e.step_count || got.status !== e.status)
        flag_error($sformatf({"result mismatch: exp x=%0d y=%0d n=%0d st=%0d,",
                              " got x=%0d y=%0d n=%0d st=%0d"},
                             e.pos_x, e.pos_y, e.step_count, e.status,
                             got.pos_x, got.pos_y, got.step_count, got.status));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet = 1'b0;   // high while neither side idles
  int   cycles = 0;

  walk_scoreboard sb;

  grws_chan_if #(.T(grws_pkg::in_item_t))  in_ch  ();
  grws_chan_if #(.T(grws_pkg::out_item_t)) out_ch ();
  grws_chan_if #(.T(grws_pkg::cfg_item_t)) cfg_ch ();

  grid_random_walk_stepper_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Stall the result channel at random, except during the quiet stretch.
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watch all three channels. Check the output beat before noting a new input
  // beat on the same edge; the output always belongs to an older item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) sb.apply_reg(cfg_ch.data.index, cfg_ch.data.wdata);
    end
  end

  // Abort a hung run. The budget covers the map clearing pass after reset.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic grws_pkg::in_item_t mk_item(logic [1:0] kind, int x, int y,
                                                 bit blk, int r);
    grws_pkg::in_item_t it;
    it.kind       = kind;
    it.cell_x     = coord_t'(x);
    it.cell_y     = coord_t'(y);
    it.blocked    = blk;
    it.rand_value = rand_t'(r);
    return it;
  endfunction

  // Send one input beat. Valid stays high into the next call unless that call
  // decides to idle first, so valid is never dropped and raised in one step.
  task automatic push_item(input grws_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid, let the last accepted beat reach the scoreboard, hold until
  // every forecast result has arrived, then give a map write time to retire.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input grws_pkg::cfg_idx_e idx, input cfg_data_t value);
    grws_pkg::cfg_item_t c;
    c.index = idx;
    c.wdata = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  // Write every register back to back; only call with the block idle.
  task automatic program_regs(input int w, input int h, input int pu, input int pd,
                              input int pl, input bit obs, input logic [19:0] limit);
    cfg_write(grws_pkg::CFG_GRID_WIDTH,   cfg_data_t'(w));
    cfg_write(grws_pkg::CFG_GRID_HEIGHT,  cfg_data_t'(h));
    cfg_write(grws_pkg::CFG_PROB_UP,      cfg_data_t'(pu));
    cfg_write(grws_pkg::CFG_PROB_DOWN,    cfg_data_t'(pd));
    cfg_write(grws_pkg::CFG_PROB_LEFT,    cfg_data_t'(pl));
    cfg_write(grws_pkg::CFG_OBSTACLES_ON, cfg_data_t'(obs));
    cfg_write(grws_pkg::CFG_MAX_STEPS,    cfg_data_t'(limit));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 1;
    if (r < 15) return 64;
    if (r < 22) return $urandom_range(0, 127);
    return $urandom_range(2, 12);
  endfunction

  function automatic int pick_prob();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return 0;
    if (r < 14) return PERMILLE;
    if (r < 30) return $urandom_range(0, PERMILLE);
    return $urandom_range(150, 350);
  endfunction

  // --------------------------------------------------------------------------
  // Directed part: edge cases under three register settings
  // --------------------------------------------------------------------------
  task automatic run_directed();
    // Reset settings: 64x64, wrap-around, center at (32,32).
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 999));   // step with no walk
    push_item(mk_item(KIND_UNUSED, 63, 63, 1, 1023));        // unused kind, dropped
    push_item(mk_item(grws_pkg::KIND_START, 32, 32, 0, 0));  // start on the center
    push_item(mk_item(grws_pkg::KIND_STEP, 63, 63, 1, 0));   // walk already ended
    push_item(mk_item(grws_pkg::KIND_START, 0, 0, 1, 1023));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 0));     // up, wrap to last row
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 250));   // down, wrap to row 0
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 500));   // left, wrap to last col
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 750));   // right, wrap to col 0
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 1023));  // draw above the scale
    push_item(mk_item(grws_pkg::KIND_START, 63, 63, 0, 0));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 999));   // right edge wraps

    // Small 5x3 grid with obstacles, every move heads left, limit of 3.
    settle_block();
    program_regs(5, 3, 0, 0, PERMILLE, 1'b1, 20'd3);
    push_item(mk_item(grws_pkg::KIND_MAP, 1, 0, 1, 0));
    push_item(mk_item(grws_pkg::KIND_START, 2, 0, 0, 0));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 10));    // into a blocked cell
    push_item(mk_item(grws_pkg::KIND_START, 40, 50, 0, 0));  // start outside the grid
    repeat (4) push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 500)); // off grid, limit
    push_item(mk_item(grws_pkg::KIND_MAP, 1, 0, 0, 0));
    push_item(mk_item(grws_pkg::KIND_START, 0, 1, 0, 0));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 500));   // off the left edge
    push_item(mk_item(grws_pkg::KIND_START, 3, 1, 0, 0));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 500));   // lands on the center

    // Width 0 and height 127 clamp to 1x64; thresholds overlap; no steps allowed.
    settle_block();
    program_regs(0, 127, PERMILLE, PERMILLE, PERMILLE, 1'b0, 20'd0);
    push_item(mk_item(grws_pkg::KIND_START, 0, 5, 0, 0));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 999));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 0));
    push_item(mk_item(grws_pkg::KIND_START, 5, 40, 1, 0));
    push_item(mk_item(grws_pkg::KIND_STEP, 0, 0, 0, 0));
  endtask

  // --------------------------------------------------------------------------
  // Random part: mostly live walks, with map edits and noise mixed in
  // --------------------------------------------------------------------------
  task automatic run_random();
    int                 per_phase, sent, sel, w, h;
    logic [19:0]        limit;
    grws_pkg::in_item_t it;
    per_phase = RAND_ITEMS / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      sel = $urandom_range(99);
      if (p == 0 || sel < 5) limit = STEPS_ALL_ONE;
      else if (sel < 15) limit = 20'($urandom_range(0, STEPS_ALL_ONE));
      else limit = 20'($urandom_range(0, 60));
      program_regs(pick_dim(), pick_dim(), pick_prob(), pick_prob(), pick_prob(),
                   1'($urandom_range(1)), limit);
      quiet = (p == QUIET_PHASE);
      w = sb.eff_dim(sb.grid_w);
      h = sb.eff_dim(sb.grid_h);
      sent = 0;
      while (sent < per_phase) begin
        // hold the sender once mid-phase until the output has fully drained
        if (p == PAUSE_PHASE && sent == per_phase / 2) settle_block();
        sel = $urandom_range(99);
        it  = mk_item(grws_pkg::KIND_STEP, $urandom_range(63), $urandom_range(63),
                      1'($urandom_range(1)), $urandom_range(0, PERMILLE - 1));
        if ($urandom_range(99) < 5) it.rand_value = rand_t'($urandom_range(PERMILLE, 1023));
        if (sel < 8) begin
          it.kind = grws_pkg::KIND_MAP;
          if ($urandom_range(99) < 80) begin
            it.cell_x = coord_t'($urandom_range(w - 1));
            it.cell_y = coord_t'($urandom_range(h - 1));
          end
          it.blocked = ($urandom_range(99) < 35);
        end else if (sel < 10) begin
          it.kind = KIND_UNUSED;
        end else if (sel < 13) begin
          it.kind = grws_pkg::KIND_START;   // anywhere, in the grid or not
        end else if (sel < 20 || (!sb.walking && $urandom_range(99) < 75)) begin
          it.kind   = grws_pkg::KIND_START;
          it.cell_x = coord_t'($urandom_range(w - 1));
          it.cell_y = coord_t'($urandom_range(h - 1));
        end
        push_item(it);
        if (it.kind != KIND_UNUSED) sent++;
      end
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();

    // Drain the output, allow a few more cycles for stray beats, then judge.
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
